/* rtl/core/robin_hood_pointer_table_defines.svh */
// Assertion macros for the pointer table RTL.
// Included by the modules that carry concurrent checks; expects clk and arst_n in scope.
`ifndef ROBIN_HOOD_POINTER_TABLE_DEFINES_SVH
`define ROBIN_HOOD_POINTER_TABLE_DEFINES_SVH
// Condition must hold in the same cycle as the trigger.
`define RHPT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
// Condition must hold in the cycle after the trigger.
`define RHPT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`endif

/* rtl/core/rhpt_pkg.sv */
// Shared types, constants and slot arithmetic for the pointer table.
// No dependencies; used by every module of the block except the generic RAM.
package rhpt_pkg;

	localparam int SLOTS      = 64;
	localparam int SW         = $clog2(SLOTS);
	localparam int CW         = $clog2(SLOTS + 1);
	localparam int ADDR_W     = 48;
	localparam int LEN_W      = 32;
	localparam int HASH_SHIFT = 3;
	localparam int HB         = ADDR_W - HASH_SHIFT;
	localparam int HCNT_W     = $clog2(HB);
	localparam int SCW        = 7;
	localparam int ENT_W      = ADDR_W + LEN_W + 2 + SW;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;
	localparam int FLAG_ROOT  = 0;
	localparam int FLAG_MARK  = 1;
	localparam logic [SCW-1:0] SLOT_COUNT_RST = 7'd53;
	localparam logic REG_SLOT_COUNT = 1'b0;

	typedef enum logic [2:0] {
		FN_INSERT  = 3'd0,
		FN_REMOVE  = 3'd1,
		FN_SETLEN  = 3'd2,
		FN_FLAGS   = 3'd3,
		FN_MARK    = 3'd4,
		FN_SWEEP   = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_MISS   = 2'd1,
		ST_FULL   = 2'd2,
		ST_MARKED = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HASH,
		S_FND_RD,
		S_FND_EV,
		S_INS_RD,
		S_INS_EV,
		S_DEL_RD,
		S_DEL_EV,
		S_SW_RD,
		S_SW_EV,
		S_CLR_RD,
		S_CLR_EV,
		S_Q_RD,
		S_Q_EM,
		S_RES
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] key;
		logic [LEN_W-1:0]  len;
		logic [1:0]        flags;
		logic [SW-1:0]     home;
	} entry_t;

	// Distance of slot i from its home slot h, modulo n.
	function automatic logic [CW-1:0] slot_dist(input logic [SW-1:0] i,
		input logic [SW-1:0] h, input logic [CW-1:0] n);
		logic [CW-1:0] a;
		logic [CW-1:0] b;
		a = CW'(i);
		b = CW'(h);
		return (a >= b) ? a - b : a + n - b;
	endfunction

	// Next slot index, wrapping at n.
	function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] i,
		input logic [CW-1:0] n);
		logic [CW-1:0] s;
		s = CW'(i) + CW'(1);
		return (s == n) ? '0 : s[SW-1:0];
	endfunction

endpackage

/* rtl/core/robin_hood_pointer_table.sv */
// Robin Hood pointer table. Hashing takes 45 address bits, one per cycle, and a done step to
// give the home slot; each probed slot is then read and evaluated. Insert walks again from
// home, remove shifts each moved entry back until one stops it, and a result state ends it.
// Sweep: visits every slot with shifts after each removal, a mark-clearing pass over all n
// slots, then the freed addresses one by one. One item in flight; busy is high meanwhile.
// Reset empties the table and sets slot_count to 53; results cannot be stalled.
`include "robin_hood_pointer_table_defines.svh"
module robin_hood_pointer_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rhpt_pkg::PADDR_W-1:0]  paddr,
	input  logic [rhpt_pkg::PDATA_W-1:0]  pwdata,
	output logic [rhpt_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  logic [2:0]                    func,
	input  logic [rhpt_pkg::ADDR_W-1:0]   block_address,
	input  logic [rhpt_pkg::LEN_W-1:0]    block_length,
	input  logic                          root_flag,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [1:0]                    flags_out,
	output logic [rhpt_pkg::ADDR_W-1:0]   entry_address,
	output logic [rhpt_pkg::LEN_W-1:0]    entry_length,
	output logic [6:0]                    entry_count,
	output logic                          final_item
);

	localparam int SW = rhpt_pkg::SW;
	localparam int CW = rhpt_pkg::CW;

	rhpt_pkg::state_t  state_q, state_d;
	logic [rhpt_pkg::SLOTS-1:0] valid_q;
	logic [CW-1:0]     cnt_q;
	logic [rhpt_pkg::SCW-1:0] slot_count_q;
	logic [CW-1:0]     n_eff;
	logic              cfg_wr;
	logic              accept;

	rhpt_pkg::func_t   func_q;
	logic [rhpt_pkg::ADDR_W-1:0] addr_q;
	logic [rhpt_pkg::LEN_W-1:0]  len_q;
	logic              root_q;
	logic [SW-1:0]     home_q;
	logic [SW-1:0]     i_q;
	logic [SW-1:0]     dj_q;
	logic [CW-1:0]     k_q;
	logic [CW-1:0]     jd_q;
	logic [CW-1:0]     swi_q;
	logic [CW-1:0]     wq_q;
	logic [CW-1:0]     rq_q;
	logic              seen_q;
	rhpt_pkg::entry_t  car_q;
	rhpt_pkg::status_t res_st_q;
	logic [1:0]        res_fl_q;
	logic [rhpt_pkg::ADDR_W-1:0] res_a_q;
	logic [rhpt_pkg::LEN_W-1:0]  res_l_q;

	logic              mod_go;
	logic              mod_done;
	logic [SW-1:0]     mod_rem;

	logic              ram_we;
	logic [SW-1:0]     ram_waddr;
	rhpt_pkg::entry_t  ram_wdata;
	logic [SW-1:0]     ram_raddr;
	logic [rhpt_pkg::ENT_W-1:0] ram_rdata;
	rhpt_pkg::entry_t  rd;
	logic              q_we;
	logic [rhpt_pkg::ADDR_W-1:0] q_rdata;

	logic              cur_vld, fnd_stop, hit, k_last, contains, is_marked;
	logic              fnd_found, fnd_miss, sw_keep, sw_last, del_move, ins_take;
	logic              full, q_last, hashed;
	logic [CW-1:0]     dcur;
	logic [SW-1:0]     i_next;
	logic [rhpt_pkg::ADDR_W-1:0] diff;

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == rhpt_pkg::REG_SLOT_COUNT) ?
		rhpt_pkg::PDATA_W'(slot_count_q) : '0;
	assign busy   = (state_q != rhpt_pkg::S_IDLE);
	assign accept = start && !busy;

	always_comb begin
		if (slot_count_q == '0) begin
			n_eff = CW'(1);
		end else if (slot_count_q > rhpt_pkg::SCW'(rhpt_pkg::SLOTS)) begin
			n_eff = CW'(rhpt_pkg::SLOTS);
		end else begin
			n_eff = CW'(slot_count_q);
		end
	end

	assign hashed = (func <= 3'(rhpt_pkg::FN_MARK));
	assign mod_go = accept && hashed;

	rhpt_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_go),
		.dividend (block_address[rhpt_pkg::ADDR_W-1:rhpt_pkg::HASH_SHIFT]),
		.modulus  (n_eff),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	rhpt_ram #(.WIDTH(rhpt_pkg::ENT_W), .DEPTH(rhpt_pkg::SLOTS)) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Freed addresses wait here until the sweep is complete and the count is final.
	rhpt_ram #(.WIDTH(rhpt_pkg::ADDR_W), .DEPTH(rhpt_pkg::SLOTS)) u_freeq (
		.clk   (clk),
		.we    (q_we),
		.waddr (wq_q[SW-1:0]),
		.wdata (rd.key),
		.raddr (rq_q[SW-1:0]),
		.rdata (q_rdata)
	);

	// Probe conditions on the slot just read.
	always_comb begin
		rd        = rhpt_pkg::entry_t'(ram_rdata);
		cur_vld   = valid_q[i_q];
		dcur      = rhpt_pkg::slot_dist(i_q, rd.home, n_eff);
		i_next    = rhpt_pkg::slot_next(i_q, n_eff);
		fnd_stop  = !cur_vld || (k_q > dcur);
		hit       = (rd.key == addr_q);
		k_last    = (k_q + CW'(1) == n_eff);
		diff      = addr_q - rd.key;
		contains  = (addr_q >= rd.key) && (diff < rhpt_pkg::ADDR_W'(rd.len));
		is_marked = rd.flags[rhpt_pkg::FLAG_MARK];
		fnd_found = !fnd_stop && hit;
		fnd_miss  = fnd_stop || (!hit && k_last);
		sw_keep   = !valid_q[swi_q[SW-1:0]] || rd.flags[rhpt_pkg::FLAG_MARK] ||
			rd.flags[rhpt_pkg::FLAG_ROOT];
		sw_last   = (swi_q + CW'(1) == n_eff);
		del_move  = cur_vld && (dcur != '0);
		ins_take  = (jd_q >= dcur);
		full      = (cnt_q >= n_eff);
		q_last    = (rq_q + CW'(1) == wq_q);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			rhpt_pkg::S_IDLE: begin
				if (accept) begin
					if (hashed) begin
						state_d = rhpt_pkg::S_HASH;
					end else if (func == 3'(rhpt_pkg::FN_SWEEP)) begin
						state_d = rhpt_pkg::S_SW_RD;
					end else begin
						state_d = rhpt_pkg::S_RES;
					end
				end
			end
			rhpt_pkg::S_HASH: begin
				if (mod_done) begin
					state_d = rhpt_pkg::S_FND_RD;
				end
			end
			rhpt_pkg::S_FND_RD: state_d = rhpt_pkg::S_FND_EV;
			rhpt_pkg::S_FND_EV: begin
				if (func_q == rhpt_pkg::FN_MARK) begin
					if (fnd_stop || (contains && !is_marked) || k_last) begin
						state_d = rhpt_pkg::S_RES;
					end else begin
						state_d = rhpt_pkg::S_FND_RD;
					end
				end else if (fnd_found) begin
					state_d = (func_q == rhpt_pkg::FN_REMOVE) ?
						rhpt_pkg::S_DEL_RD : rhpt_pkg::S_RES;
				end else if (fnd_miss) begin
					state_d = (func_q == rhpt_pkg::FN_INSERT && !full) ?
						rhpt_pkg::S_INS_RD : rhpt_pkg::S_RES;
				end else begin
					state_d = rhpt_pkg::S_FND_RD;
				end
			end
			rhpt_pkg::S_INS_RD: state_d = rhpt_pkg::S_INS_EV;
			rhpt_pkg::S_INS_EV: begin
				state_d = (!cur_vld || k_last) ? rhpt_pkg::S_RES : rhpt_pkg::S_INS_RD;
			end
			rhpt_pkg::S_DEL_RD: state_d = rhpt_pkg::S_DEL_EV;
			rhpt_pkg::S_DEL_EV: begin
				if (!del_move || k_last) begin
					state_d = (func_q == rhpt_pkg::FN_SWEEP) ?
						rhpt_pkg::S_SW_RD : rhpt_pkg::S_RES;
				end else begin
					state_d = rhpt_pkg::S_DEL_RD;
				end
			end
			rhpt_pkg::S_SW_RD: state_d = rhpt_pkg::S_SW_EV;
			rhpt_pkg::S_SW_EV: begin
				if (!sw_keep) begin
					state_d = rhpt_pkg::S_DEL_RD;
				end else begin
					state_d = sw_last ? rhpt_pkg::S_CLR_RD : rhpt_pkg::S_SW_RD;
				end
			end
			rhpt_pkg::S_CLR_RD: state_d = rhpt_pkg::S_CLR_EV;
			rhpt_pkg::S_CLR_EV: begin
				if (!sw_last) begin
					state_d = rhpt_pkg::S_CLR_RD;
				end else begin
					state_d = (wq_q == '0) ? rhpt_pkg::S_RES : rhpt_pkg::S_Q_RD;
				end
			end
			rhpt_pkg::S_Q_RD: state_d = rhpt_pkg::S_Q_EM;
			rhpt_pkg::S_Q_EM: state_d = q_last ? rhpt_pkg::S_IDLE : rhpt_pkg::S_Q_RD;
			rhpt_pkg::S_RES: state_d = rhpt_pkg::S_IDLE;
			default: state_d = rhpt_pkg::S_IDLE;
		endcase
	end

	// Memory controls and result ports.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = i_q;
		ram_wdata = rd;
		ram_raddr = i_q;
		q_we      = 1'b0;
		case (state_q)
			rhpt_pkg::S_FND_EV: begin
				if (func_q == rhpt_pkg::FN_SETLEN && fnd_found) begin
					ram_we        = 1'b1;
					ram_wdata.len = len_q;
				end else if (func_q == rhpt_pkg::FN_MARK && !fnd_stop && contains &&
					!is_marked) begin
					ram_we = 1'b1;
					ram_wdata.flags[rhpt_pkg::FLAG_MARK] = 1'b1;
				end
			end
			rhpt_pkg::S_INS_EV: begin
				ram_we    = !cur_vld || ins_take;
				ram_wdata = car_q;
			end
			rhpt_pkg::S_DEL_EV: begin
				ram_we    = del_move;
				ram_waddr = dj_q;
			end
			rhpt_pkg::S_SW_RD: ram_raddr = swi_q[SW-1:0];
			rhpt_pkg::S_SW_EV: q_we = !sw_keep;
			rhpt_pkg::S_CLR_RD: ram_raddr = swi_q[SW-1:0];
			rhpt_pkg::S_CLR_EV: begin
				ram_we    = valid_q[swi_q[SW-1:0]];
				ram_waddr = swi_q[SW-1:0];
				ram_wdata.flags[rhpt_pkg::FLAG_MARK] = 1'b0;
			end
			default: ram_we = 1'b0;
		endcase
	end

	always_comb begin
		done          = (state_q == rhpt_pkg::S_RES) || (state_q == rhpt_pkg::S_Q_EM);
		final_item    = (state_q == rhpt_pkg::S_RES) ||
			((state_q == rhpt_pkg::S_Q_EM) && q_last);
		entry_count   = 7'(cnt_q);
		if (state_q == rhpt_pkg::S_Q_EM) begin
			status        = rhpt_pkg::ST_DONE;
			flags_out     = '0;
			entry_address = q_rdata;
			entry_length  = '0;
		end else begin
			status        = res_st_q;
			flags_out     = res_fl_q;
			entry_address = res_a_q;
			entry_length  = res_l_q;
		end
	end

	// Control state: occupancy, count, configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= rhpt_pkg::S_IDLE;
			valid_q      <= '0;
			cnt_q        <= '0;
			slot_count_q <= rhpt_pkg::SLOT_COUNT_RST;
		end else begin
			state_q <= state_d;
			if (cfg_wr && paddr[2] == rhpt_pkg::REG_SLOT_COUNT) begin
				slot_count_q <= pwdata[rhpt_pkg::SCW-1:0];
				valid_q      <= '0;
				cnt_q        <= '0;
			end else begin
				case (state_q)
					rhpt_pkg::S_FND_EV: begin
						if (func_q == rhpt_pkg::FN_REMOVE && fnd_found) begin
							valid_q[i_q] <= 1'b0;
						end
					end
					rhpt_pkg::S_INS_EV: begin
						if (!cur_vld) begin
							valid_q[i_q] <= 1'b1;
							cnt_q        <= cnt_q + CW'(1);
						end
					end
					rhpt_pkg::S_DEL_EV: begin
						if (del_move) begin
							valid_q[dj_q] <= 1'b1;
							valid_q[i_q]  <= 1'b0;
						end
						if ((!del_move || k_last) && cnt_q != '0) begin
							cnt_q <= cnt_q - CW'(1);
						end
					end
					rhpt_pkg::S_SW_EV: begin
						if (!sw_keep) begin
							valid_q[swi_q[SW-1:0]] <= 1'b0;
						end
					end
					default: cnt_q <= cnt_q;
				endcase
			end
		end
	end

	// Working registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			rhpt_pkg::S_IDLE: begin
				if (accept) begin
					func_q   <= rhpt_pkg::func_t'(func);
					addr_q   <= block_address;
					len_q    <= block_length;
					root_q   <= root_flag;
					res_st_q <= rhpt_pkg::ST_MISS;
					res_fl_q <= '0;
					res_a_q  <= '0;
					res_l_q  <= '0;
					seen_q   <= 1'b0;
					wq_q     <= '0;
					swi_q    <= '0;
				end
			end
			rhpt_pkg::S_HASH: begin
				if (mod_done) begin
					home_q <= mod_rem;
					i_q    <= mod_rem;
					k_q    <= '0;
				end
			end
			rhpt_pkg::S_FND_EV: begin
				if (func_q == rhpt_pkg::FN_MARK) begin
					if (!fnd_stop && contains) begin
						if (!is_marked) begin
							res_st_q <= rhpt_pkg::ST_DONE;
							res_fl_q <= rd.flags | 2'b10;
							res_a_q  <= rd.key;
							res_l_q  <= rd.len;
						end else if (!seen_q) begin
							seen_q   <= 1'b1;
							res_st_q <= rhpt_pkg::ST_MARKED;
							res_fl_q <= rd.flags;
							res_a_q  <= rd.key;
							res_l_q  <= rd.len;
						end
					end
					i_q <= i_next;
					k_q <= k_q + CW'(1);
				end else if (fnd_found) begin
					if (func_q != rhpt_pkg::FN_INSERT) begin
						res_st_q <= rhpt_pkg::ST_DONE;
					end
					if (func_q == rhpt_pkg::FN_FLAGS) begin
						res_fl_q <= rd.flags;
					end
					dj_q <= i_q;
					i_q  <= i_next;
					k_q  <= '0;
				end else if (fnd_miss) begin
					if (func_q == rhpt_pkg::FN_INSERT) begin
						if (full) begin
							res_st_q <= rhpt_pkg::ST_FULL;
						end else begin
							res_st_q  <= rhpt_pkg::ST_DONE;
							i_q       <= home_q;
							k_q       <= '0;
							jd_q      <= '0;
							car_q.key   <= addr_q;
							car_q.len   <= len_q;
							car_q.flags <= {1'b0, root_q};
							car_q.home  <= home_q;
						end
					end
				end else begin
					i_q <= i_next;
					k_q <= k_q + CW'(1);
				end
			end
			rhpt_pkg::S_INS_EV: begin
				// The carried entry is swapped out when the resident one is no farther from home.
				if (cur_vld && ins_take) begin
					car_q <= rd;
					jd_q  <= dcur + CW'(1);
				end else begin
					jd_q  <= jd_q + CW'(1);
				end
				i_q <= i_next;
				k_q <= k_q + CW'(1);
			end
			rhpt_pkg::S_DEL_EV: begin
				if (del_move) begin
					dj_q <= i_q;
					i_q  <= i_next;
					k_q  <= k_q + CW'(1);
				end
			end
			rhpt_pkg::S_SW_EV: begin
				if (sw_keep) begin
					swi_q <= sw_last ? '0 : swi_q + CW'(1);
				end else begin
					dj_q <= swi_q[SW-1:0];
					i_q  <= rhpt_pkg::slot_next(swi_q[SW-1:0], n_eff);
					k_q  <= '0;
					wq_q <= wq_q + CW'(1);
				end
			end
			rhpt_pkg::S_CLR_EV: begin
				swi_q <= swi_q + CW'(1);
				rq_q  <= '0;
			end
			rhpt_pkg::S_Q_EM: rq_q <= rq_q + CW'(1);
			default: rq_q <= rq_q;
		endcase
	end

	`RHPT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= n_eff, "live count above slot count")
	`RHPT_ASSERT_NEXT(a_final_idle, done && final_item, !busy, "busy after last item")
	`RHPT_ASSERT_NOW(a_q_order, state_q == rhpt_pkg::S_Q_EM, rq_q < wq_q,
		"free queue read past its fill")
	`RHPT_ASSERT_NOW(a_cnt_valid, state_q == rhpt_pkg::S_IDLE,
		CW'($countones(valid_q)) == cnt_q, "occupied slots disagree with count")

endmodule

/* rtl/core/rhpt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rhpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/rhpt_mod.sv */
// Bit-serial modulo unit: remainder of the shifted address by the slot count.
// Depends on rhpt_pkg and the assertion macro header.
`include "robin_hood_pointer_table_defines.svh"
module rhpt_mod (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [rhpt_pkg::HB-1:0]   dividend,
	input  logic [rhpt_pkg::CW-1:0]   modulus,
	output logic                      done,
	output logic [rhpt_pkg::SW-1:0]   rem
);

	logic                          run_q;
	logic                          done_q;
	logic [rhpt_pkg::HCNT_W-1:0]   cnt_q;
	logic [rhpt_pkg::HB-1:0]       sh_q;
	logic [rhpt_pkg::SW-1:0]       r_q;
	logic [rhpt_pkg::SW:0]         t;
	logic [rhpt_pkg::SW:0]         t_red;
	logic                          last;

	function automatic logic CW_rem_ok(input logic [rhpt_pkg::SW-1:0] r,
		input logic [rhpt_pkg::CW-1:0] m);
		return rhpt_pkg::CW'(r) < m;
	endfunction

	// One dividend bit per cycle; the remainder stays below the modulus.
	always_comb begin
		t     = {r_q, sh_q[rhpt_pkg::HB-1]};
		t_red = (t >= (rhpt_pkg::SW + 1)'(modulus)) ? t - (rhpt_pkg::SW + 1)'(modulus) : t;
		last  = (cnt_q == rhpt_pkg::HCNT_W'(rhpt_pkg::HB - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && last;
			if (start) begin
				run_q <= 1'b1;
			end else if (last) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= dividend;
			r_q   <= '0;
			cnt_q <= '0;
		end else if (run_q) begin
			sh_q  <= {sh_q[rhpt_pkg::HB-2:0], 1'b0};
			r_q   <= t_red[rhpt_pkg::SW-1:0];
			cnt_q <= cnt_q + rhpt_pkg::HCNT_W'(1);
		end
	end

	assign done = done_q;
	assign rem  = r_q;

	`RHPT_ASSERT_NEXT(a_mod_runs, start, run_q, "modulo unit did not start")
	`RHPT_ASSERT_NOW(a_mod_rem, done, CW_rem_ok(r_q, modulus), "remainder not below modulus")

endmodule
